// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// immediate-implication and next-cycle-implication property checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSTW_ASSERT_I(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSTW_ASSERT_NX(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSTW_ASSERT_I(lbl, ante, cons)
`define HSTW_ASSERT_NX(lbl, ante, cons)
`endif
`endif

// ----- rtl/hstw_pkg.sv -----
// ----------------------------------------------------------------------------
// hstw_pkg
// types and constants of the hermite spline time warp unit
// ----------------------------------------------------------------------------
package hstw_pkg;

  localparam int unsigned MaxAnchors = 16;
  localparam int unsigned IdxW       = $clog2(MaxAnchors);
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SlopeW     = 24;
  localparam int unsigned ResW       = 32;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 72;
  localparam int unsigned SW         = 17;
  localparam int unsigned DivSteps   = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [31:0] C2Base = 32'sd196608;
  localparam logic signed [31:0] C3Base = -32'sd131072;
  localparam logic [SW-1:0]      SOne   = 17'h10000;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CLAMP_LO = 10'b00_0000_0010,
    ST_CLAMP_HI = 10'b00_0000_0100,
    ST_SEARCH   = 10'b00_0000_1000,
    ST_LOAD_LO  = 10'b00_0001_0000,
    ST_DIV      = 10'b00_0010_0000,
    ST_COEF     = 10'b00_0100_0000,
    ST_MUL      = 10'b00_1000_0000,
    ST_ADD      = 10'b01_0000_0000,
    ST_SPARE    = 10'b10_0000_0000
  } state_e;

  function automatic logic [ResW-1:0] sat32(input logic signed [34:0] x);
    logic [ResW-1:0] r;
    if (x > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/hermite_spline_time_warp_unit.sv -----
// ----------------------------------------------------------------------------
// hermite_spline_time_warp_unit
// anchor table, sequential segment search, bit-serial divider and one shared
// multiplier evaluating a cubic hermite curve and its derivative
// ----------------------------------------------------------------------------
// load transaction: writes one anchor table entry, no result
// query transaction: clamp low, clamp high, segment search, load low, divide (skipped
//   when the segment is not ascending or t is at one of its ends), coefficients, then
//   multiply/add steps; search steps one table read a cycle; one query at a time; the
//   result register lets the next transaction in, a result still held downstream stalls the final step
// rst_ni clears control state and sets segment_count to 1; table is not cleared
`include "assert_macros.svh"

module hermite_spline_time_warp_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [3:0]                     cfg_wr_data_i,   // segment_count
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // anchor_index[3:0], time_value[35:4], anchor_slope[59:36], zero pad
  input  logic [hstw_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,  // cmd
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // warped_param[31:0], param_rate[63:32], segment_found[67:64], zero pad
  output logic [hstw_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import hstw_pkg::*;

  logic [TimeW-1:0]         mem_time [MaxAnchors];
  logic signed [SlopeW-1:0] mem_slope [MaxAnchors];

  state_e                   state_q, state_d;
  logic [3:0]               cnt_q;
  logic [2:0]               step_q;
  logic [3:0]               segcnt_q;
  logic [IdxW-1:0]          n_q, seg_q, rd_addr;
  logic [TimeW-1:0]         t_q, hi_q, r_q, rd_time_q;
  logic signed [SlopeW-1:0] rd_slope_q, m0_q, m1_q;
  logic [SW-1:0]            s_q;
  logic signed [31:0]       c2_q, c3_q, acc_q, op, term;
  logic signed [49:0]       prod_q;
  logic signed [34:0]       sum;
  logic [ResW-1:0]          val_q;
  logic                     m_valid_q;
  logic [OutDataW-1:0]      m_data_q;
  logic                     in_acc, go;
  logic                     res_ld;
  logic [32:0]              r2, r2_sub;
  logic                     ge;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign go     = (seg_q < n_q - 4'd1) && (t_q > rd_time_q);
  assign r2     = {r_q, 1'b0};
  assign r2_sub = r2 - {1'b0, hi_q};
  assign ge     = (r2 >= {1'b0, hi_q});
  assign res_ld = (state_q == ST_ADD) && (step_q == 3'd4) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    case (state_q)
      ST_CLAMP_LO: rd_addr = n_q;
      ST_CLAMP_HI: rd_addr = 4'd1;
      ST_SEARCH:   rd_addr = go ? seg_q + 4'd2 : seg_q;
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    case (step_q)
      3'd0:    op = c3_q;
      3'd3:    op = c3_q + (c3_q <<< 1);
      default: op = acc_q;
    endcase
    case (step_q)
      3'd0:    term = c2_q;
      3'd2:    term = {{(32-IdxW-16){1'b0}}, seg_q, 16'h0000};
      3'd3:    term = c2_q <<< 1;
      default: term = 32'(m0_q);
    endcase
    sum = 35'($signed(prod_q[49:16])) + 35'(term);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser_i == CMD_LOAD)) begin
      mem_time[s_axis_tdata_i[3:0]]   <= s_axis_tdata_i[35:4];
      mem_slope[s_axis_tdata_i[3:0]]  <= s_axis_tdata_i[59:36];
    end
    rd_time_q  <= mem_time[rd_addr];
    rd_slope_q <= mem_slope[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc && (s_axis_tuser_i == CMD_QUERY)) state_d = ST_CLAMP_LO;
      ST_CLAMP_LO: state_d = ST_CLAMP_HI;
      ST_CLAMP_HI: state_d = ST_SEARCH;
      ST_SEARCH:   if (!go) state_d = ST_LOAD_LO;
      ST_LOAD_LO: begin
        if ((hi_q <= rd_time_q) || (t_q <= rd_time_q) || (t_q >= hi_q)) begin
          state_d = ST_COEF;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:      if (cnt_q == 4'd0) state_d = ST_COEF;
      ST_COEF:     state_d = ST_MUL;
      ST_MUL:      state_d = ST_ADD;
      ST_ADD: begin
        if (step_q != 3'd4) begin
          state_d = ST_MUL;
        end else if (!m_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      segcnt_q  <= 4'd1;
      m_valid_q <= 1'b0;
      seg_q     <= '0;
      n_q       <= 4'd1;
      cnt_q     <= '0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) segcnt_q <= cfg_wr_data_i;
      if (res_ld) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          seg_q <= '0;
          n_q   <= (segcnt_q == 4'd0) ? 4'd1 : segcnt_q;
        end
        ST_SEARCH: if (go) seg_q <= seg_q + 4'd1;
        ST_LOAD_LO: cnt_q <= 4'(DivSteps - 1);
        ST_DIV:     cnt_q <= cnt_q - 4'd1;
        ST_COEF:    step_q <= '0;
        ST_ADD: begin
          if (step_q != 3'd4) begin
            step_q <= step_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:     t_q <= s_axis_tdata_i[35:4];
      ST_CLAMP_LO: if (t_q < rd_time_q) t_q <= rd_time_q;
      ST_CLAMP_HI: if (t_q > rd_time_q) t_q <= rd_time_q;
      ST_SEARCH: begin
        hi_q <= rd_time_q;
        m1_q <= rd_slope_q;
      end
      ST_LOAD_LO: begin
        m0_q <= rd_slope_q;
        s_q  <= '0;
        r_q  <= t_q - rd_time_q;
        hi_q <= hi_q - rd_time_q;
        if ((hi_q > rd_time_q) && (t_q > rd_time_q) && (t_q >= hi_q)) s_q <= SOne;
      end
      ST_DIV: begin
        r_q <= ge ? r2_sub[31:0] : r2[31:0];
        s_q <= {s_q[SW-2:0], ge};
      end
      ST_COEF: begin
        c2_q <= C2Base - (32'(m0_q) <<< 1) - 32'(m1_q);
        c3_q <= C3Base + 32'(m0_q) + 32'(m1_q);
      end
      ST_MUL: prod_q <= op * $signed({1'b0, s_q});
      ST_ADD: begin
        acc_q <= sum[31:0];
        if (step_q == 3'd2) val_q <= sat32(sum);
        if (res_ld) begin
          m_data_q <= {4'h0, seg_q, sat32(sum), val_q};
        end
      end
      default: ;
    endcase
  end

  `HSTW_ASSERT_I(a_seg_range, state_q != ST_IDLE, seg_q < n_q)
  `HSTW_ASSERT_NX(a_query_busy, in_acc && (s_axis_tuser_i == CMD_QUERY), !s_axis_tready_o)
  `HSTW_ASSERT_I(a_div_bound, state_q == ST_DIV, r_q < hi_q)

endmodule

// ----- tb/sv/hermite_spline_time_warp_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_spline_time_warp_unit_checker
// watches the load, query, result and register channels, keeps its own copy
// of the anchor table, predicts each query result and compares field by field
// ----------------------------------------------------------------------------
module hermite_spline_time_warp_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [3:0]                    cfg_wr_data_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [hstw_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [hstw_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import hstw_pkg::*;

  typedef struct packed {
    logic [31:0] warped;
    logic [31:0] rate;
    logic [3:0]  seg;
  } warp_result_t;

  logic [31:0]        knot_time [MaxAnchors];
  logic signed [23:0] knot_slope[MaxAnchors];
  logic [3:0]         seg_count;
  warp_result_t       warp_q[$];

  assign pending_o = warp_q.size();

  function automatic longint fl16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic warp_result_t warp_eval(logic [31:0] tq);
    warp_result_t r;
    int unsigned n, sg;
    logic [31:0] t, lo, hi;
    longint s, p0, p1, m0, m1, c2, c3, v, rt;
    n = (seg_count == 0) ? 1 : seg_count;
    if (n > MaxAnchors - 1) n = MaxAnchors - 1;
    t = tq;
    if (t < knot_time[0]) t = knot_time[0];
    if (t > knot_time[n]) t = knot_time[n];
    sg = 0;
    while (sg < n - 1 && t > knot_time[sg+1]) sg++;
    lo = knot_time[sg];
    hi = knot_time[sg+1];
    if (hi <= lo || t <= lo) s = 0;
    else if (t >= hi) s = 65536;
    else s = longint'(({32'd0, t - lo} << 16) / {32'd0, hi - lo});
    p0 = longint'(sg) * 65536;
    p1 = longint'(sg + 1) * 65536;
    m0 = knot_slope[sg];
    m1 = knot_slope[sg+1];
    c2 = 3 * (p1 - p0) - 2 * m0 - m1;
    c3 = 2 * (p0 - p1) + m0 + m1;
    v = c2 + fl16(s * c3);
    v = m0 + fl16(s * v);
    v = p0 + fl16(s * v);
    rt = 2 * c2 + fl16(3 * c3 * s);
    rt = m0 + fl16(s * rt);
    r.warped = clip32(v);
    r.rate = clip32(rt);
    r.seg = sg[3:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    warp_result_t e;
    logic [3:0] idx;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      seg_count <= 4'd1;
      fail_count_o <= 0;
    end else begin
      if (cfg_wr_en_i) seg_count <= cfg_wr_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == CMD_LOAD) begin
          idx = s_axis_tdata_i[3:0];
          knot_time[idx] = s_axis_tdata_i[35:4];
          knot_slope[idx] = s_axis_tdata_i[59:36];
        end else begin
          warp_q.insert(warp_q.size(), warp_eval(s_axis_tdata_i[35:4]));
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (warp_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          e = warp_q.pop_front();
          if (m_axis_tdata_i[31:0] !== e.warped) begin
            $error("warped_param expected %h actual %h", e.warped, m_axis_tdata_i[31:0]);
            errs++;
          end
          if (m_axis_tdata_i[63:32] !== e.rate) begin
            $error("param_rate expected %h actual %h", e.rate, m_axis_tdata_i[63:32]);
            errs++;
          end
          if (m_axis_tdata_i[67:64] !== e.seg) begin
            $error("segment_found expected %h actual %h", e.seg, m_axis_tdata_i[67:64]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

// ----- tb/sv/hermite_spline_time_warp_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_spline_time_warp_unit_test
// loads ascending anchor tables under several segment counts, runs directed
// and random queries with random stalls on both streams, and gives a verdict
// ----------------------------------------------------------------------------
module hermite_spline_time_warp_unit_test;
  import hstw_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_wr_en_i = 1'b0;
  logic [3:0]            cfg_wr_data_i = 4'd0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  int                    fail_count, pending;
  bit                    calm;
  logic [31:0]           knot_t[16];
  int unsigned           nseg;

  always #5 clk_i = ~clk_i;

  hermite_spline_time_warp_unit i_dut (.*);

  hermite_spline_time_warp_unit_checker i_checker (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 31);
  end

  task automatic send(logic cmd, logic [3:0] idx, logic [31:0] t, logic [23:0] sl);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {4'd0, sl, t, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_segments(logic [3:0] n);
    settle();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= n;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  // ascending times; mode 1 gives tight spacing with zero-length segments
  task automatic load_table(int mode);
    logic [31:0] t;
    logic [23:0] sl;
    t = (mode == 2) ? 32'd0 : $urandom_range(1000);
    for (int i = 0; i < 16; i++) begin
      knot_t[i] = t;
      case ($urandom_range(3))
        0: sl = 24'h7FFFFF;
        1: sl = 24'h800000;
        default: sl = 24'($urandom());
      endcase
      send(CMD_LOAD, i[3:0], t, sl);
      if (mode == 1) t = t + $urandom_range(3);
      else if (mode == 2) t = t + 32'h1000_0000 - 32'd1;
      else t = t + $urandom_range(1, 100000);
    end
  endtask

  task automatic query_random();
    logic [31:0] t;
    int k;
    k = $urandom_range(nseg);
    case ($urandom_range(5))
      0: t = knot_t[k];
      1: t = knot_t[k] + 1;
      2: t = $urandom();
      3: t = {($urandom_range(1) == 1), 31'h0} |
             (32'h7FFF_FFFF & {32{($urandom_range(1) == 1)}});
      default: t = knot_t[0] + $urandom_range(knot_t[nseg] - knot_t[0] + 2);
    endcase
    send(CMD_QUERY, 4'($urandom()), t, 24'($urandom()));
  endtask

  initial begin
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed part
    nseg = 1;
    load_table(2);
    send(CMD_QUERY, 4'hF, 32'h0, 24'hFFFFFF);
    send(CMD_QUERY, 4'h0, 32'hFFFF_FFFF, 24'h0);
    send(CMD_QUERY, 4'h5, knot_t[1], 24'h0);
    send(CMD_QUERY, 4'h5, knot_t[1] >> 1, 24'h0);
    set_segments(4'd15);
    nseg = 15;
    send(CMD_QUERY, 4'h0, 32'hFFFF_FFFF, 24'h0);
    send(CMD_QUERY, 4'h0, knot_t[7], 24'h0);
    send(CMD_QUERY, 4'h0, knot_t[7] + 1, 24'h0);
    set_segments(4'd0);
    nseg = 1;
    send(CMD_QUERY, 4'h0, knot_t[1] - 5, 24'h0);
    load_table(1);
    set_segments(4'd15);
    nseg = 15;
    for (int i = 0; i < 6; i++) query_random();
    // random part over several settings
    for (int ph = 0; ph < 10; ph++) begin
      nseg = $urandom_range(1, 15);
      if (ph == 3) nseg = 15;
      if (ph == 4) nseg = 1;
      set_segments(nseg[3:0]);
      load_table((ph % 4 == 1) ? 1 : 0);
      calm = (ph == 5);
      for (int i = 0; i < 60; i++) query_random();
      calm = 1'b0;
    end
    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/hstw_pkg.sv
rtl/hermite_spline_time_warp_unit.sv
tb/sv/hermite_spline_time_warp_unit_checker.sv
tb/sv/hermite_spline_time_warp_unit_test.sv
